FILE: design/stpu_pkg.sv
// ----------------------------------------------------------------------------
// stpu_pkg
// Shared types, codes and character helpers for the string to unsigned parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stpu_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int INDEX_BITS_DEF = 16;
  localparam int BASE_W         = 6;
  localparam int CH_W           = 8;
  localparam int STATUS_W       = 2;

  localparam logic [BASE_W-1:0] BASE_AUTO   = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE    = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [BASE_W-1:0] RADIX_LIMIT = 6'd36;
  localparam logic [BASE_W-1:0] DIG_NONE    = 6'd36;

  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CH_W-1:0] LETTER_OFS = 8'd10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WS,
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_PREFIXED
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_DIGIT = 2'd1,
    ST_BAD_BASE = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef struct packed {
    phase_t              phase;
    logic                negative;
    logic [BASE_W-1:0]   active_base;
    logic                overflowed;
  } ctrl_t;

  // digit value of a character, DIG_NONE when it is no digit in any radix
  function automatic logic [BASE_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] t;
    t = {2'b00, DIG_NONE};
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      t = c - CH_LO_A + LETTER_OFS;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      t = c - CH_UP_A + LETTER_OFS;
    end
    return t[BASE_W-1:0];
  endfunction

endpackage

FILE: design/stpu_mac.sv
// ----------------------------------------------------------------------------
// stpu_mac
// Accumulator times radix plus digit, with a flag when the sum leaves the
// value width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stpu_mac
  import stpu_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0] acc,
  input  logic [BASE_W-1:0]     base,
  input  logic [BASE_W-1:0]     digit,
  output logic [VALUE_BITS-1:0] sum,
  output logic                  ovf
);

  localparam int FULL_W = VALUE_BITS + BASE_W + 1;

  logic [FULL_W-1:0] full;

  assign full = FULL_W'(acc) * FULL_W'(base) + FULL_W'(digit);
  assign sum  = full[VALUE_BITS-1:0];
  assign ovf  = |full[FULL_W-1:VALUE_BITS];

endmodule

FILE: design/stpu_step.sv
// ----------------------------------------------------------------------------
// stpu_step
// Next-state and result logic for one character of the parse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stpu_step
  import stpu_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic [CH_W-1:0]       ch,
  input  logic                  first,
  input  logic [BASE_W-1:0]     conversion_base,
  input  ctrl_t                 cur,
  input  logic [VALUE_BITS-1:0] acc,
  input  logic [INDEX_BITS-1:0] pos,
  output ctrl_t                 nxt,
  output logic [VALUE_BITS-1:0] acc_next,
  output logic [INDEX_BITS-1:0] pos_next,
  output logic                  res_valid,
  output logic [VALUE_BITS-1:0] res_value,
  output logic [INDEX_BITS-1:0] res_index,
  output status_t               res_status
);

  ctrl_t                 w;
  logic [VALUE_BITS-1:0] acc_w;
  logic [INDEX_BITS-1:0] pos_w;
  logic [INDEX_BITS-1:0] pos_inc;
  logic                  bad_base;
  logic [BASE_W-1:0]     eb;
  logic [BASE_W-1:0]     digit;
  logic                  is_digit;
  logic [VALUE_BITS-1:0] mac_sum;
  logic                  mac_ovf;

  // a new string restarts the state before the character is looked at
  always_comb begin
    w        = cur;
    acc_w    = acc;
    pos_w    = pos;
    bad_base = 1'b0;
    if (first) begin
      w.active_base = conversion_base;
      w.negative    = 1'b0;
      w.overflowed  = 1'b0;
      w.phase       = PH_WS;
      acc_w         = '0;
      pos_w         = '0;
      bad_base      = (conversion_base == BASE_ONE) || (conversion_base > RADIX_LIMIT);
    end
  end

  // radix the character is tested against in the current phase
  always_comb begin
    eb = w.active_base;
    if (w.active_base == BASE_AUTO) begin
      eb = (w.phase == PH_ZERO) ? BASE_OCT : BASE_DEC;
    end
  end

  assign digit    = digit_of(ch);
  assign is_digit = digit < eb;
  assign pos_inc  = (pos_w == '1) ? pos_w : pos_w + 1'b1;

  stpu_mac #(
    .VALUE_BITS (VALUE_BITS)
  ) u_mac (
    .acc   (acc_w),
    .base  (eb),
    .digit (digit),
    .sum   (mac_sum),
    .ovf   (mac_ovf)
  );

  always_comb begin
    nxt        = w;
    acc_next   = acc_w;
    pos_next   = pos_w;
    res_valid  = 1'b0;
    res_value  = '0;
    res_index  = '0;
    res_status = ST_OK;

    if (bad_base) begin
      nxt.phase  = PH_IDLE;
      res_valid  = 1'b1;
      res_status = ST_BAD_BASE;
    end else begin
      case (w.phase)
        PH_WS, PH_START: begin
          if (w.phase == PH_WS && (ch == CH_SPACE || ch inside {[CH_TAB:CH_CR]})) begin
            pos_next = pos_inc;
          end else if (w.phase == PH_WS && (ch == CH_PLUS || ch == CH_MINUS)) begin
            nxt.negative = (ch == CH_MINUS);
            nxt.phase    = PH_START;
            pos_next     = pos_inc;
          end else if (ch == CH_ZERO &&
                       (w.active_base == BASE_AUTO || w.active_base == BASE_HEX)) begin
            nxt.phase = PH_ZERO;
            pos_next  = pos_inc;
          end else begin
            nxt.active_base = eb;
            if (is_digit) begin
              nxt.phase = PH_DIGITS;
              pos_next  = pos_inc;
              if (!w.overflowed) begin
                if (mac_ovf) nxt.overflowed = 1'b1;
                else acc_next = mac_sum;
              end
            end else begin
              nxt.phase  = PH_IDLE;
              res_valid  = 1'b1;
              res_status = ST_NO_DIGIT;
            end
          end
        end
        PH_ZERO, PH_PREFIXED, PH_DIGITS: begin
          if (w.phase == PH_ZERO && (ch == CH_LO_X || ch == CH_UP_X)) begin
            nxt.active_base = BASE_HEX;
            nxt.phase       = PH_PREFIXED;
            pos_next        = pos_inc;
          end else if (is_digit) begin
            nxt.active_base = eb;
            nxt.phase       = PH_DIGITS;
            pos_next        = pos_inc;
            if (!w.overflowed) begin
              if (mac_ovf) nxt.overflowed = 1'b1;
              else acc_next = mac_sum;
            end
          end else if (w.phase == PH_PREFIXED) begin
            // bare hex prefix: nothing converted
            nxt.phase  = PH_IDLE;
            res_valid  = 1'b1;
            res_status = ST_NO_DIGIT;
          end else begin
            nxt.active_base = eb;
            nxt.phase       = PH_IDLE;
            res_valid       = 1'b1;
            res_index       = pos_w;
            if (w.overflowed) begin
              res_value  = '1;
              res_status = ST_RANGE;
            end else begin
              res_value  = w.negative ? ('0 - acc_w) : acc_w;
              res_status = ST_OK;
            end
          end
        end
        default: begin
          // idle, no string open: character dropped
        end
      endcase
    end
  end

endmodule

FILE: design/string_to_unsigned_parser_unit.sv
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_unit
// Streaming strtoul: one character per request, one result per string.
//
// Input channel (in_valid/in_ready) carries ch and first; first marks the
// opening character of a string. Leading whitespace, an optional sign and a
// hex prefix are consumed; the first non-digit closes the string and makes
// one result request (value, end_index, status) on out_valid/out_ready.
// The radix comes from register conversion_base (APB, byte address 0) and is
// latched at the first character of each string.
// Throughput: one character per cycle unless the result register stalls.
// A character passes an input register and then the parse logic (one
// multiply-add by the radix) into the state and result registers, so a
// result is presented once its closing character reaches the result register.
// When the receiver stalls, the result register holds and the input
// register fills; in_ready drops only once both are occupied.
// Reset (rst, synchronous) empties both registers, closes any open string
// and sets conversion_base to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module string_to_unsigned_parser_unit
  import stpu_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CH_W-1:0]       ch,
  input  logic                  first,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] value,
  output logic [INDEX_BITS-1:0] end_index,
  output logic [STATUS_W-1:0]   status
);

  logic [BASE_W-1:0] conversion_base;
  logic              reg_hit;

  logic              s_valid;
  logic [CH_W-1:0]   s_ch;
  logic              s_first;
  logic              fire;

  ctrl_t                 ctrl;
  ctrl_t                 ctrl_next;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  logic [INDEX_BITS-1:0] pos;
  logic [INDEX_BITS-1:0] pos_next;
  logic                  res_valid;
  logic [VALUE_BITS-1:0] res_value;
  logic [INDEX_BITS-1:0] res_index;
  status_t               res_status;

  // configuration port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);
  assign prdata  = reg_hit ? {{(32-BASE_W){1'b0}}, conversion_base} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      conversion_base <= BASE_AUTO;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      conversion_base <= pwdata[BASE_W-1:0];
    end
  end

  // input register
  assign fire     = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (fire) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_ch    <= ch;
      s_first <= first;
    end
  end

  stpu_step #(
    .VALUE_BITS (VALUE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_step (
    .ch              (s_ch),
    .first           (s_first),
    .conversion_base (conversion_base),
    .cur             (ctrl),
    .acc             (acc),
    .pos             (pos),
    .nxt             (ctrl_next),
    .acc_next        (acc_next),
    .pos_next        (pos_next),
    .res_valid       (res_valid),
    .res_value       (res_value),
    .res_index       (res_index),
    .res_status      (res_status)
  );

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase       <= PH_IDLE;
      ctrl.negative    <= 1'b0;
      ctrl.active_base <= BASE_AUTO;
      ctrl.overflowed  <= 1'b0;
      acc              <= '0;
      pos              <= '0;
    end else if (fire) begin
      ctrl <= ctrl_next;
      acc  <= acc_next;
      pos  <= pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      value     <= res_value;
      end_index <= res_index;
      status    <= res_status;
    end
  end

  // failed conversions report nothing consumed
  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_DIGIT || status == ST_BAD_BASE)
      |-> value == '0 && end_index == '0)
    else $error("failed conversion with nonzero value or index");

  a_range_sat : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_RANGE |-> value == '1)
    else $error("range error without saturated value");

  // a character waiting on a stalled result must not be lost
  a_hold_stage : assert property (@(posedge clk) disable iff (rst)
    s_valid && out_valid && !out_ready |=> s_valid && $stable(s_ch) && $stable(s_first))
    else $error("input register changed while output stalled");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid && !s_valid && ctrl.phase == PH_IDLE)
    else $error("registers not empty after reset");

endmodule
